FILE: rtl/cmfd_pkg.sv
// Shared widths, register indexes, reset values and the CRC-8 step for the CAN frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package cmfd_pkg;

   // Field widths
   localparam int unsigned ID_WIDTH    = 29;
   localparam int unsigned DLC_WIDTH   = 4;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned TERM_WIDTH  = 16;
   localparam int unsigned KIND_WIDTH  = 2;
   localparam int unsigned INDEX_WIDTH = 3;

   // Only full eight-byte frames are accepted
   localparam logic [DLC_WIDTH-1:0] FRAME_DLC = 4'd8;

   // Control register indexes
   localparam logic [INDEX_WIDTH-1:0] REG_PROTOCOL_VERSION   = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_SAFE_BASE_ID       = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_VOTE_REQUEST_BASE  = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_VOTE_GRANT_BASE    = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] REG_HEARTBEAT_BASE_ID  = 3'd4;
   localparam logic [INDEX_WIDTH-1:0] REG_NODE_LIMIT         = 3'd5;
   localparam logic [INDEX_WIDTH-1:0] REG_ROLE_LIMIT         = 3'd6;
   localparam logic [INDEX_WIDTH-1:0] REG_NODE_STATE_LIMIT   = 3'd7;

   // Reset values of the control registers
   localparam logic [BYTE_WIDTH-1:0] RST_PROTOCOL_VERSION  = 8'd1;
   localparam logic [ID_WIDTH-1:0]   RST_SAFE_BASE_ID      = 29'd256;
   localparam logic [ID_WIDTH-1:0]   RST_VOTE_REQUEST_BASE = 29'd512;
   localparam logic [ID_WIDTH-1:0]   RST_VOTE_GRANT_BASE   = 29'd768;
   localparam logic [ID_WIDTH-1:0]   RST_HEARTBEAT_BASE_ID = 29'd1792;
   localparam logic [BYTE_WIDTH-1:0] RST_NODE_LIMIT        = 8'd16;
   localparam logic [BYTE_WIDTH-1:0] RST_ROLE_LIMIT        = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] RST_NODE_STATE_LIMIT  = 8'd3;

   // Message kinds
   localparam logic [KIND_WIDTH-1:0] KIND_HEARTBEAT    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_VOTE_GRANT   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_VOTE_REQUEST = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_SAFE         = 2'd3;

   // CRC-8, polynomial 0x1D, MSB first
   localparam logic [BYTE_WIDTH-1:0] CRC_POLY   = 8'h1D;
   localparam logic [BYTE_WIDTH-1:0] CRC_INIT   = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] CRC_XOROUT = 8'hFF;

   // One byte through the CRC register; flattens to an XOR network
   function automatic logic [BYTE_WIDTH-1:0] crc8_byte(input logic [BYTE_WIDTH-1:0] crc,
                                                        input logic [BYTE_WIDTH-1:0] data);
      logic [BYTE_WIDTH-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < BYTE_WIDTH; b++) begin
         if (c[BYTE_WIDTH-1]) begin
            c = {c[BYTE_WIDTH-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/can_message_frame_decoder.sv
// CAN frame checker and decoder: range classification, CRC-8 and bound checks.
//
// Usage:
//  - req_* channel: one received frame per word (identifier, length code and
//    the eight payload bytes as separate fields), valid/ready handshake.
//  - rsp_* channel: one result word per frame, accept flag plus unpacked
//    fields; every field but rsp_accepted is zero for a rejected frame.
//  - csr_* channel: register writes (index, data), always ready. Write only
//    while no frame is in flight.
// The frame is registered in the input register when req is accepted, checked
// by one pass of combinational logic (four range subtractors, a seven-byte
// CRC-8 XOR network, byte compares) and the result is registered in the result
// register, which drives rsp_valid. Throughput is one frame per cycle while the
// receiver takes results; the input register and the result register each
// advance whenever the stage after them is free.
// When the receiver stalls, the result stays put, the input register fills
// and then req_ready drops; nothing is lost.
// Reset empties both stages and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module can_message_frame_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // frame input
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [cmfd_pkg::ID_WIDTH-1:0]        req_can_id,
   input  wire logic [cmfd_pkg::DLC_WIDTH-1:0]       req_dlc,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_version_byte,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_src_byte,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_role_byte,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_state_byte,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_term_low,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_term_high,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_arg_byte,
   input  wire logic [cmfd_pkg::BYTE_WIDTH-1:0]      req_crc_byte,
   // result output
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_accepted,
   output      logic [cmfd_pkg::KIND_WIDTH-1:0]      rsp_msg_kind,
   output      logic [cmfd_pkg::BYTE_WIDTH-1:0]      rsp_version_out,
   output      logic [cmfd_pkg::BYTE_WIDTH-1:0]      rsp_source_node,
   output      logic [cmfd_pkg::BYTE_WIDTH-1:0]      rsp_node_role,
   output      logic [cmfd_pkg::BYTE_WIDTH-1:0]      rsp_sender_state,
   output      logic [cmfd_pkg::TERM_WIDTH-1:0]      rsp_term,
   output      logic [cmfd_pkg::BYTE_WIDTH-1:0]      rsp_argument,
   // register writes
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [cmfd_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [cmfd_pkg::ID_WIDTH-1:0]        csr_data
);

   localparam int unsigned IW = cmfd_pkg::ID_WIDTH;
   localparam int unsigned BW = cmfd_pkg::BYTE_WIDTH;

   // control registers
   logic [BW-1:0] protocol_version_ff;
   logic [IW-1:0] safe_base_ff;
   logic [IW-1:0] vote_request_base_ff;
   logic [IW-1:0] vote_grant_base_ff;
   logic [IW-1:0] heartbeat_base_ff;
   logic [BW-1:0] node_limit_ff;
   logic [BW-1:0] role_limit_ff;
   logic [BW-1:0] node_state_limit_ff;

   // input stage
   logic                             in_valid_ff;
   logic [IW-1:0]                    can_id_ff;
   logic [cmfd_pkg::DLC_WIDTH-1:0]   dlc_ff;
   logic [BW-1:0]                    version_ff;
   logic [BW-1:0]                    src_ff;
   logic [BW-1:0]                    role_ff;
   logic [BW-1:0]                    state_ff;
   logic [BW-1:0]                    term_low_ff;
   logic [BW-1:0]                    term_high_ff;
   logic [BW-1:0]                    arg_ff;
   logic [BW-1:0]                    crc_ff;

   // result stage
   logic                             out_valid_ff;
   logic                             accepted_ff, accepted_in;
   logic [cmfd_pkg::KIND_WIDTH-1:0]  kind_ff, kind_in;
   logic [BW-1:0]                    version_out_ff, version_out_in;
   logic [BW-1:0]                    source_ff, source_in;
   logic [BW-1:0]                    role_out_ff, role_out_in;
   logic [BW-1:0]                    state_out_ff, state_out_in;
   logic [cmfd_pkg::TERM_WIDTH-1:0]  term_ff, term_in;
   logic [BW-1:0]                    argument_ff, argument_in;

   // handshake
   logic out_load;
   logic in_load;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_version_ff  <= cmfd_pkg::RST_PROTOCOL_VERSION;
         safe_base_ff         <= cmfd_pkg::RST_SAFE_BASE_ID;
         vote_request_base_ff <= cmfd_pkg::RST_VOTE_REQUEST_BASE;
         vote_grant_base_ff   <= cmfd_pkg::RST_VOTE_GRANT_BASE;
         heartbeat_base_ff    <= cmfd_pkg::RST_HEARTBEAT_BASE_ID;
         node_limit_ff        <= cmfd_pkg::RST_NODE_LIMIT;
         role_limit_ff        <= cmfd_pkg::RST_ROLE_LIMIT;
         node_state_limit_ff  <= cmfd_pkg::RST_NODE_STATE_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cmfd_pkg::REG_PROTOCOL_VERSION:  protocol_version_ff  <= csr_data[BW-1:0];
            cmfd_pkg::REG_SAFE_BASE_ID:      safe_base_ff         <= csr_data;
            cmfd_pkg::REG_VOTE_REQUEST_BASE: vote_request_base_ff <= csr_data;
            cmfd_pkg::REG_VOTE_GRANT_BASE:   vote_grant_base_ff   <= csr_data;
            cmfd_pkg::REG_HEARTBEAT_BASE_ID: heartbeat_base_ff    <= csr_data;
            cmfd_pkg::REG_NODE_LIMIT:        node_limit_ff        <= csr_data[BW-1:0];
            cmfd_pkg::REG_ROLE_LIMIT:        role_limit_ff        <= csr_data[BW-1:0];
            cmfd_pkg::REG_NODE_STATE_LIMIT:  node_state_limit_ff  <= csr_data[BW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         can_id_ff    <= req_can_id;
         dlc_ff       <= req_dlc;
         version_ff   <= req_version_byte;
         src_ff       <= req_src_byte;
         role_ff      <= req_role_byte;
         state_ff     <= req_state_byte;
         term_low_ff  <= req_term_low;
         term_high_ff <= req_term_high;
         arg_ff       <= req_arg_byte;
         crc_ff       <= req_crc_byte;
      end
   end

   // range offsets: id - base with a borrow bit on top
   logic [IW:0] hb_diff, vg_diff, vr_diff, sf_diff;
   logic        hb_hit, vg_hit, vr_hit, sf_hit;

   assign hb_diff = {1'b0, can_id_ff} - {1'b0, heartbeat_base_ff};
   assign vg_diff = {1'b0, can_id_ff} - {1'b0, vote_grant_base_ff};
   assign vr_diff = {1'b0, can_id_ff} - {1'b0, vote_request_base_ff};
   assign sf_diff = {1'b0, can_id_ff} - {1'b0, safe_base_ff};

   // hit when 1 <= id - base <= node limit
   assign hb_hit = (hb_diff[IW:BW] == '0) && (hb_diff[BW-1:0] != '0)
                   && (hb_diff[BW-1:0] <= node_limit_ff);
   assign vg_hit = (vg_diff[IW:BW] == '0) && (vg_diff[BW-1:0] != '0)
                   && (vg_diff[BW-1:0] <= node_limit_ff);
   assign vr_hit = (vr_diff[IW:BW] == '0) && (vr_diff[BW-1:0] != '0)
                   && (vr_diff[BW-1:0] <= node_limit_ff);
   assign sf_hit = (sf_diff[IW:BW] == '0) && (sf_diff[BW-1:0] != '0)
                   && (sf_diff[BW-1:0] <= node_limit_ff);

   // first hit wins, heartbeat first
   logic                            id_hit;
   logic [cmfd_pkg::KIND_WIDTH-1:0] kind_sel;
   logic [BW-1:0]                   offset_sel;

   always_comb begin
      id_hit     = 1'b1;
      kind_sel   = cmfd_pkg::KIND_HEARTBEAT;
      offset_sel = '0;
      priority if (hb_hit) begin
         offset_sel = hb_diff[BW-1:0];
      end else if (vg_hit) begin
         kind_sel   = cmfd_pkg::KIND_VOTE_GRANT;
         offset_sel = vg_diff[BW-1:0];
      end else if (vr_hit) begin
         kind_sel   = cmfd_pkg::KIND_VOTE_REQUEST;
         offset_sel = vr_diff[BW-1:0];
      end else if (sf_hit) begin
         kind_sel   = cmfd_pkg::KIND_SAFE;
         offset_sel = sf_diff[BW-1:0];
      end else begin
         id_hit = 1'b0;
      end
   end

   // CRC-8 over payload bytes 0 to 6
   logic [BW-1:0] crc_calc;

   always_comb begin
      crc_calc = cmfd_pkg::CRC_INIT;
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, version_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, src_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, role_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, state_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, term_low_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, term_high_ff);
      crc_calc = cmfd_pkg::crc8_byte(crc_calc, arg_ff);
      crc_calc = crc_calc ^ cmfd_pkg::CRC_XOROUT;
   end

   // all checks, then zero the fields of a rejected frame
   logic frame_ok;

   assign frame_ok = id_hit
                     && (dlc_ff == cmfd_pkg::FRAME_DLC)
                     && (version_ff == protocol_version_ff)
                     && (crc_ff == crc_calc)
                     && (src_ff == offset_sel)
                     && (src_ff != '0)
                     && (src_ff <= node_limit_ff)
                     && (role_ff <= role_limit_ff)
                     && (state_ff <= node_state_limit_ff);

   always_comb begin
      accepted_in    = frame_ok;
      kind_in        = '0;
      version_out_in = '0;
      source_in      = '0;
      role_out_in    = '0;
      state_out_in   = '0;
      term_in        = '0;
      argument_in    = '0;
      if (frame_ok) begin
         kind_in        = kind_sel;
         version_out_in = version_ff;
         source_in      = src_ff;
         role_out_in    = role_ff;
         state_out_in   = state_ff;
         term_in        = {term_high_ff, term_low_ff};
         argument_in    = arg_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         accepted_ff    <= accepted_in;
         kind_ff        <= kind_in;
         version_out_ff <= version_out_in;
         source_ff      <= source_in;
         role_out_ff    <= role_out_in;
         state_out_ff   <= state_out_in;
         term_ff        <= term_in;
         argument_ff    <= argument_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_msg_kind     = kind_ff;
   assign rsp_version_out  = version_out_ff;
   assign rsp_source_node  = source_ff;
   assign rsp_node_role    = role_out_ff;
   assign rsp_sender_state = state_out_ff;
   assign rsp_term         = term_ff;
   assign rsp_argument     = argument_ff;

   // checks
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      in_load |=> in_valid_ff)
      else $error("accepted frame missing from input register");

   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(can_id_ff))
      else $error("input register lost a frame while result stalled");

   a_reject_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_msg_kind == '0 && rsp_term == '0
         && rsp_version_out == '0 && rsp_source_node == '0 && rsp_argument == '0
         && rsp_node_role == '0 && rsp_sender_state == '0)
      else $error("rejected frame carries non-zero fields");

   a_accept_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_source_node != '0)
      else $error("accepted frame with source node zero");

endmodule
`default_nettype wire
